// ===== rtl/ptic_pkg.sv =====
// shared types and constants of the prescaled timers and interrupt controller
package ptic_pkg;

  // flag register layout
  localparam int unsigned FlagBits      = 11;
  localparam int unsigned SoftBit       = 5;
  localparam int unsigned TimerBit0     = 6;
  localparam int unsigned SampleDoneBit = 10;
  localparam int unsigned LevelTop      = 7;
  localparam int unsigned NumTimers     = 3;
  localparam int unsigned CountBits     = 8;
  localparam int unsigned ModeBits      = 3;
  localparam int unsigned LevelBits     = 3;
  localparam int unsigned LevelSrcs     = LevelTop + 1;

  // operation codes of an input item
  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_TIMER_WRITE = 3'd1,
    OP_SUB_ENABLE  = 3'd2,
    OP_SUB_SET     = 3'd3,
    OP_SUB_RESET   = 3'd4,
    OP_MAIN_ENABLE = 3'd5,
    OP_MAIN_SET    = 3'd6,
    OP_MAIN_RESET  = 3'd7
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LEVEL_BIT0 = 2'd0,
    CFG_LEVEL_BIT1 = 2'd1,
    CFG_LEVEL_BIT2 = 2'd2
  } cfg_idx_e;

  typedef logic [FlagBits-1:0] flags_t;

  // input item
  typedef struct packed {
    logic [2:0]          operation;
    logic [1:0]          timer_select;
    logic [FlagBits-1:0] write_data;
  } ptic_in_t;

  // result item
  typedef struct packed {
    logic [FlagBits-1:0]  sub_pending_mask;
    logic [LevelBits-1:0] sub_level;
    logic                 main_irq;
  } ptic_out_t;

endpackage

// ===== rtl/ptic_if.sv =====
// valid/ready stream interfaces for the input and result channels
interface ptic_in_if;
  import ptic_pkg::*;
  logic     valid;
  logic     ready;
  ptic_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptic_out_if;
  import ptic_pkg::*;
  logic      valid;
  logic      ready;
  ptic_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/prescaled_timers_interrupt_controller.sv =====
// Three prescaled 8-bit timers with a sound-side and a main-side interrupt controller.
//
// Channels: in_i carries one operation per transfer (sample tick, timer write,
// enable write, pending set or pending reset); out_o carries one result per
// input: the enabled-and-pending sound-side mask, the level of its lowest
// pending source and the main-side irq. The user must write the three level
// registers via cfg_we_i/cfg_idx_i/cfg_data_i only while idle; the block does not check.
// Update: the state and the output register are both loaded at the input
// transfer, so the item's result sits in the output register the cycle after.
// Throughput: one item per cycle while out_o is not stalled; the state update
// and the level lookup are a single pass of short logic into the output register.
// Stall: in_i.ready is high while the output register is empty or is being
// emptied in the same cycle, so a stalled receiver holds the input back
// after exactly one result is queued, and nothing is lost.
// Reset: rst_ni clears all timers, modes, enables, pending bits and level
// registers, sets every prescaler to one and empties the output register.
module prescaled_timers_interrupt_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [7:0]       cfg_data_i,
  ptic_in_if.sink          in_i,
  ptic_out_if.source       out_o
);
  import ptic_pkg::*;

  logic [LevelSrcs-1:0] level_mask_q [LevelBits];

  logic [CountBits-1:0] count_q [NumTimers];
  logic [CountBits-1:0] count_d [NumTimers];
  logic [ModeBits-1:0]  mode_q  [NumTimers];
  logic [ModeBits-1:0]  mode_d  [NumTimers];
  logic [CountBits-1:0] presc_q [NumTimers];
  logic [CountBits-1:0] presc_d [NumTimers];

  flags_t sub_en_q, sub_en_d, sub_pend_q, sub_pend_d;
  flags_t main_en_q, main_en_d, main_pend_q, main_pend_d;

  logic      out_valid_q;
  ptic_out_t out_q, out_d;
  logic      in_xfer;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // level register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < LevelBits; b++) level_mask_q[b] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LEVEL_BIT0: level_mask_q[0] <= cfg_data_i;
        CFG_LEVEL_BIT1: level_mask_q[1] <= cfg_data_i;
        CFG_LEVEL_BIT2: level_mask_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state of timers and controllers for the offered item
  always_comb begin
    flags_t                 timer_flags;
    logic [CountBits-1:0]   cnt_inc;
    logic [ModeBits-1:0]    new_mode;
    flags_t                 data;
    count_d     = count_q;
    mode_d      = mode_q;
    presc_d     = presc_q;
    sub_en_d    = sub_en_q;
    sub_pend_d  = sub_pend_q;
    main_en_d   = main_en_q;
    main_pend_d = main_pend_q;
    timer_flags = '0;
    cnt_inc     = '0;
    data        = in_i.data.write_data;
    new_mode    = data[CountBits +: ModeBits];

    unique case (op_e'(in_i.data.operation))
      OP_TICK: begin
        for (int t = 0; t < NumTimers; t++) begin
          if (presc_q[t] > CountBits'(1)) begin
            presc_d[t] = presc_q[t] - CountBits'(1);
          end else begin
            presc_d[t] = CountBits'(1) << mode_q[t];
            cnt_inc    = count_q[t] + CountBits'(1);
            count_d[t] = cnt_inc;
            if (cnt_inc == '0) timer_flags[TimerBit0 + t] = 1'b1;
          end
        end
        sub_pend_d  = sub_pend_q | timer_flags;
        sub_pend_d[SampleDoneBit] = 1'b1;
        main_pend_d = main_pend_q | timer_flags;
      end
      OP_TIMER_WRITE: begin
        for (int t = 0; t < NumTimers; t++) begin
          if (in_i.data.timer_select == 2'(t)) begin
            count_d[t] = data[CountBits-1:0];
            if (new_mode != mode_q[t]) begin
              mode_d[t]  = new_mode;
              presc_d[t] = CountBits'(1) << new_mode;
            end
          end
        end
      end
      OP_SUB_ENABLE:  sub_en_d = data;
      OP_SUB_SET:     if (data[SoftBit]) sub_pend_d[SoftBit] = 1'b1;
      OP_SUB_RESET:   sub_pend_d = sub_pend_q & ~data;
      OP_MAIN_ENABLE: main_en_d = data;
      OP_MAIN_SET:    if (data[SoftBit]) main_pend_d[SoftBit] = 1'b1;
      OP_MAIN_RESET:  main_pend_d = main_pend_q & ~data;
      default: ;
    endcase
  end

  // result from the updated state: lowest enabled pending source picks the level
  always_comb begin
    flags_t                  mask;
    logic [3:0]              src;
    logic [ModeBits-1:0]     lvl_idx;
    mask = sub_en_d & sub_pend_d;
    src  = '0;
    for (int i = FlagBits - 1; i >= 0; i--) begin
      if (mask[i]) src = 4'(i);
    end
    lvl_idx = (src > 4'(LevelTop)) ? ModeBits'(LevelTop) : src[ModeBits-1:0];
    out_d.sub_pending_mask = mask;
    out_d.sub_level = (mask == '0) ? '0 :
        {level_mask_q[2][lvl_idx], level_mask_q[1][lvl_idx], level_mask_q[0][lvl_idx]};
    out_d.main_irq = |(main_en_d & main_pend_d);
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NumTimers; t++) begin
        count_q[t] <= '0;
        mode_q[t]  <= '0;
        presc_q[t] <= CountBits'(1);
      end
      sub_en_q    <= '0;
      sub_pend_q  <= '0;
      main_en_q   <= '0;
      main_pend_q <= '0;
    end else if (in_xfer) begin
      count_q     <= count_d;
      mode_q      <= mode_d;
      presc_q     <= presc_d;
      sub_en_q    <= sub_en_d;
      sub_pend_q  <= sub_pend_d;
      main_en_q   <= main_en_d;
      main_pend_q <= main_pend_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) out_q <= out_d;
  end

endmodule
